// ----- sv/rpc_pkg.sv -----
// Package for the relay pulse controller: request codes, register indexes,
// field widths and the relay count. No dependencies.
package rpc_pkg;

    localparam int NUM_RELAYS = 4;
    localparam int SLOT_COUNT = 8;
    localparam int MASK_W     = 4;
    localparam int REQ_W      = 3;
    localparam int IDX_W      = 3;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET   = 3'd0,
        REQ_PULSE = 3'd1,
        REQ_GET   = 3'd2,
        REQ_TICK  = 3'd3,
        REQ_INIT  = 3'd4
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE   = 1'b1;

    // Mask bit of relay i; relays past the mask width read as 0.
    function automatic logic mask_bit(input logic [MASK_W-1:0] mask, input int i);
        if (i < MASK_W) begin
            return mask[i];
        end
        return 1'b0;
    endfunction

endpackage

// ----- sv/relay_pulse_controller.sv -----
// Relay pulse controller: one request word in, one status word out.
// Depends on rpc_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries a request word:
//   set, pulse, get, millisecond tick or init. Output channel
//   (o_out_valid / i_out_stall) returns one status word per request,
//   showing the relay state after that request.
//   Configuration: i_cfg_we with i_cfg_index 0 writes the enable mask,
//   index 1 the safe-level mask. Write only while no request is in flight.
// Timing and throughput
//   The status word is valid in the cycle after its request is taken. One
//   request per cycle is sustained when not stalled; the per-relay deadline
//   compares and the deadline add settle ahead of the output register.
// Stall
//   While the output register holds a word and the receiver stalls, the
//   input is stalled too; a word taken in the same cycle frees the slot.
// Reset
//   Synchronous, active low: masks, time counter, drive levels and pulses
//   clear, and the output register empties.
module relay_pulse_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpc_pkg::MASK_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rpc_pkg::REQ_W-1:0]     i_req_type,
    input  logic [rpc_pkg::IDX_W-1:0]     i_relay_index,
    input  logic                          i_relay_on,
    input  logic [rpc_pkg::MS_W-1:0]      i_pulse_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic                          o_relay_level,
    output logic [rpc_pkg::MASK_W-1:0]    o_relay_levels,
    output logic [rpc_pkg::MASK_W-1:0]    o_pulsing_mask
);
    import rpc_pkg::*;

    logic [MASK_W-1:0]     r_enable_mask;
    logic [MASK_W-1:0]     r_safe_mask;
    logic [TIME_W-1:0]     r_time;
    logic [SLOT_COUNT-1:0] r_drive;
    logic [SLOT_COUNT-1:0] r_active;
    logic [TIME_W-1:0]     r_deadline [SLOT_COUNT];

    logic [TIME_W-1:0]     n_time;
    logic [SLOT_COUNT-1:0] n_drive;
    logic [SLOT_COUNT-1:0] n_active;
    logic [TIME_W-1:0]     n_deadline [SLOT_COUNT];
    logic                  n_accepted;
    logic                  n_level;
    logic [MASK_W-1:0]     n_levels;
    logic [MASK_W-1:0]     n_pulsing;

    logic                  r_out_valid;
    logic                  r_accepted;
    logic                  r_level;
    logic [MASK_W-1:0]     r_levels;
    logic [MASK_W-1:0]     r_pulsing;

    logic                  in_take;
    logic                  idx_ok;
    logic                  idx_enabled;
    logic                  idx_safe;
    logic [TIME_W-1:0]     time_inc;
    logic [TIME_W-1:0]     pulse_end;
    t_req                  req;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;
    assign req        = t_req'(i_req_type);
    assign idx_ok     = {{(32-IDX_W){1'b0}}, i_relay_index} < NUM_RELAYS;
    assign time_inc   = r_time + {{(TIME_W-1){1'b0}}, 1'b1};
    assign pulse_end  = r_time + {{(TIME_W-MS_W){1'b0}}, i_pulse_ms};

    always_comb begin
        idx_enabled = 1'b0;
        idx_safe    = 1'b0;
        for (int i = 0; i < NUM_RELAYS; i++) begin
            if (i_relay_index == IDX_W'(i)) begin
                idx_enabled = mask_bit(r_enable_mask, i);
                idx_safe    = mask_bit(r_safe_mask, i);
            end
        end
    end

    always_comb begin
        logic [TIME_W-1:0] diff;
        n_time     = r_time;
        n_drive    = r_drive;
        n_active   = r_active;
        n_deadline = r_deadline;
        n_accepted = 1'b1;
        n_level    = 1'b0;
        diff       = '0;
        case (req)
            REQ_SET, REQ_PULSE: begin
                if (!idx_ok || !idx_enabled) begin
                    n_accepted = 1'b0;
                end else if (req == REQ_SET) begin
                    n_drive[i_relay_index]    = i_relay_on;
                    n_active[i_relay_index]   = 1'b0;
                    n_deadline[i_relay_index] = '0;
                end else begin
                    n_drive[i_relay_index]    = ~idx_safe;
                    n_active[i_relay_index]   = 1'b1;
                    n_deadline[i_relay_index] = pulse_end;
                end
            end
            REQ_GET: begin
                if (idx_ok) begin
                    n_level = r_drive[i_relay_index];
                end
            end
            REQ_TICK: begin
                n_time = time_inc;
                // expire when the wrapped difference is not negative
                for (int i = 0; i < NUM_RELAYS; i++) begin
                    diff = time_inc - r_deadline[i];
                    if (r_active[i] && !diff[TIME_W-1]) begin
                        n_drive[i]    = mask_bit(r_safe_mask, i);
                        n_active[i]   = 1'b0;
                        n_deadline[i] = '0;
                    end
                end
            end
            REQ_INIT: begin
                for (int i = 0; i < NUM_RELAYS; i++) begin
                    n_drive[i]    = mask_bit(r_safe_mask, i);
                    n_active[i]   = 1'b0;
                    n_deadline[i] = '0;
                end
            end
            default: begin
                n_accepted = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_levels  = '0;
        n_pulsing = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < NUM_RELAYS) begin
                n_levels[i]  = n_drive[i];
                n_pulsing[i] = n_active[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= '0;
            r_safe_mask   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable_mask <= i_cfg_data;
                CFG_SAFE:   r_safe_mask   <= i_cfg_data;
                default:    r_safe_mask   <= r_safe_mask;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_drive  <= '0;
            r_active <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_deadline[i] <= '0;
            end
        end else if (in_take) begin
            r_time     <= n_time;
            r_drive    <= n_drive;
            r_active   <= n_active;
            r_deadline <= n_deadline;
        end
    end

    // output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_accepted <= n_accepted;
            r_level    <= n_level;
            r_levels   <= n_levels;
            r_pulsing  <= n_pulsing;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_relay_level  = r_level;
    assign o_relay_levels = r_levels;
    assign o_pulsing_mask = r_pulsing;

endmodule

// ----- sv/rpc_checker.sv -----
// Port-level checks for the relay pulse controller, bound to the top level.
// Depends on rpc_pkg.
module rpc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [rpc_pkg::REQ_W-1:0]     i_req_type,
    input logic [rpc_pkg::IDX_W-1:0]     i_relay_index,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_accepted,
    input logic                          o_relay_level,
    input logic [rpc_pkg::MASK_W-1:0]    o_relay_levels,
    input logic [rpc_pkg::MASK_W-1:0]    o_pulsing_mask
);
    import rpc_pkg::*;

    logic in_take;
    assign in_take = i_in_valid && !o_in_stall;

    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_accepted)
            && $stable(o_relay_level) && $stable(o_relay_levels)
            && $stable(o_pulsing_mask))
        else $error("stalled output word changed");

    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_out_valid)
        else $error("no output word after an accepted request");

    a_level_only_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_req_type != REQ_GET) |=> !o_relay_level)
        else $error("relay level reported outside a get request");

    a_get_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_req_type == REQ_GET)
            && ({{(32-IDX_W){1'b0}}, i_relay_index} >= NUM_RELAYS)
            |=> !o_relay_level)
        else $error("out-of-range get reported a level");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_req_type == REQ_INIT) |=> (o_pulsing_mask == '0) && o_accepted)
        else $error("init left a pulse pending");

endmodule

bind relay_pulse_controller rpc_checker u_rpc_checker (.*);

// ----- tb/sv/tb_relay_pulse_controller.sv -----
// Testbench for relay_pulse_controller: directed and random request words,
// checked word by word against an in-bench model of the relay bank.
// Depends on rpc_pkg and the relay_pulse_controller RTL.
module tb_relay_pulse_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import rpc_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic              accepted;
        logic              relay_level;
        logic [MASK_W-1:0] relay_levels;
        logic [MASK_W-1:0] pulsing_mask;
    } t_status;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MASK_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [IDX_W-1:0]     i_relay_index;
    logic                 i_relay_on;
    logic [MS_W-1:0]      i_pulse_ms;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_accepted;
    logic                 o_relay_level;
    logic [MASK_W-1:0]    o_relay_levels;
    logic [MASK_W-1:0]    o_pulsing_mask;

    relay_pulse_controller u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_relay_index  (i_relay_index),
        .i_relay_on     (i_relay_on),
        .i_pulse_ms     (i_pulse_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_relay_level  (o_relay_level),
        .o_relay_levels (o_relay_levels),
        .o_pulsing_mask (o_pulsing_mask)
    );

    // Model of the relay bank
    logic [MASK_W-1:0] en_mask_m;
    logic [MASK_W-1:0] safe_mask_m;
    logic [TIME_W-1:0] ms_clock_m;
    logic              drive_m    [NUM_RELAYS];
    logic              pending_m  [NUM_RELAYS];
    logic [TIME_W-1:0] deadline_m [NUM_RELAYS];

    t_status status_q[$];
    int      mismatches = 0;
    bit      no_idle = 0;
    bit      hold_req = 0;
    int      stall_left = 0;

    always #6 i_clk = ~i_clk;

    function automatic logic mask_at(input logic [MASK_W-1:0] mask, input int i);
        return (i < MASK_W) ? mask[i] : 1'b0;
    endfunction

    function automatic void clear_model();
        ms_clock_m = '0;
        en_mask_m = '0;
        safe_mask_m = '0;
        for (int i = 0; i < NUM_RELAYS; i++) begin
            drive_m[i] = 1'b0;
            pending_m[i] = 1'b0;
            deadline_m[i] = '0;
        end
    endfunction

    // Apply one request to the model and return the status word it yields.
    function automatic t_status apply_request(input logic [REQ_W-1:0] req,
                                              input logic [IDX_W-1:0] idx,
                                              input logic on,
                                              input logic [MS_W-1:0] ms);
        t_status           st;
        int                n;
        bit                in_range;
        logic [TIME_W-1:0] diff;
        n = int'(idx);
        in_range = (n < NUM_RELAYS);
        st = '0;
        st.accepted = 1'b1;
        if (req == REQ_SET || req == REQ_PULSE) begin
            if (!in_range || !mask_at(en_mask_m, n)) begin
                st.accepted = 1'b0;
            end else if (req == REQ_SET) begin
                pending_m[n] = 1'b0;
                deadline_m[n] = '0;
                drive_m[n] = on;
            end else begin
                drive_m[n] = ~mask_at(safe_mask_m, n);
                deadline_m[n] = ms_clock_m + TIME_W'(ms);
                pending_m[n] = 1'b1;
            end
        end else if (req == REQ_GET) begin
            if (in_range) begin
                st.relay_level = drive_m[n];
            end
        end else if (req == REQ_TICK) begin
            ms_clock_m = ms_clock_m + TIME_W'(1);
            for (int i = 0; i < NUM_RELAYS; i++) begin
                diff = ms_clock_m - deadline_m[i];
                // expire when the wrapped difference is not negative
                if (pending_m[i] && !diff[TIME_W-1]) begin
                    drive_m[i] = mask_at(safe_mask_m, i);
                    pending_m[i] = 1'b0;
                    deadline_m[i] = '0;
                end
            end
        end else if (req == REQ_INIT) begin
            for (int i = 0; i < NUM_RELAYS; i++) begin
                drive_m[i] = mask_at(safe_mask_m, i);
                pending_m[i] = 1'b0;
                deadline_m[i] = '0;
            end
        end
        for (int i = 0; i < NUM_RELAYS && i < MASK_W; i++) begin
            st.relay_levels[i] = drive_m[i];
            st.pulsing_mask[i] = pending_m[i];
        end
        return st;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_len();
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                            input logic on, input logic [MS_W-1:0] ms);
        int gap;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_relay_index <= idx;
        i_relay_on <= on;
        i_pulse_ms <= ms;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        status_q.push_back(apply_request(req, idx, on, ms));
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_masks(input logic [MASK_W-1:0] en, input logic [MASK_W-1:0] safe);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data <= en;
        @(posedge i_clk);
        i_cfg_index <= CFG_SAFE;
        i_cfg_data <= safe;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        en_mask_m = en;
        safe_mask_m = safe;
    endtask

    task automatic send_random_req();
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        logic [MS_W-1:0]  ms;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) req = REQ_SET;
        else if (pick < 45) req = REQ_PULSE;
        else if (pick < 65) req = REQ_GET;
        else if (pick < 95) req = REQ_TICK;
        else if (pick < 98) req = REQ_INIT;
        else req = REQ_W'($urandom_range(5, 7));
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(4, 7))
                                          : IDX_W'($urandom_range(0, NUM_RELAYS - 1));
        pick = $urandom_range(0, 9);
        if (pick < 7) ms = MS_W'($urandom_range(0, 6));
        else if (pick < 9) ms = MS_W'($urandom_range(0, 64));
        else ms = MS_W'($urandom);
        send_req(req, idx, 1'(($urandom)), ms);
    endtask

    task automatic report_mismatch(input string fld, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, fld, want, got);
        end
    endtask

    // Output side: pop the oldest expectation for each word taken.
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected status word", 0, 1);
            end else begin
                want = status_q.pop_front();
                if (o_accepted !== want.accepted)
                    report_mismatch("accepted", int'(want.accepted), int'(o_accepted));
                if (o_relay_level !== want.relay_level)
                    report_mismatch("relay_level", int'(want.relay_level),
                                    int'(o_relay_level));
                if (o_relay_levels !== want.relay_levels)
                    report_mismatch("relay_levels", int'(want.relay_levels),
                                    int'(o_relay_levels));
                if (o_pulsing_mask !== want.pulsing_mask)
                    report_mismatch("pulsing_mask", int'(want.pulsing_mask),
                                    int'(o_pulsing_mask));
            end
        end
    end

    // Receiver stall pattern; a hold request stalls for a long counted stretch.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 0;
                stall_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                stall_left = pick_len() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_reset_rejects();
        // masks are clear after reset, so set and pulse are refused
        send_req(REQ_SET, 3'd0, 1'b1, 16'd0);
        send_req(REQ_PULSE, 3'd3, 1'b0, 16'hFFFF);
        send_req(REQ_GET, 3'd7, 1'b1, 16'd0);
        send_req(3'd5, 3'd1, 1'b0, 16'd0);
        send_req(3'd7, 3'd2, 1'b1, 16'hFFFF);
        drain();
    endtask

    task automatic test_levels();
        write_masks(4'b1011, 4'b0101);
        send_req(REQ_INIT, 3'd0, 1'b0, 16'd0);
        send_req(REQ_SET, 3'd0, 1'b1, 16'd0);
        send_req(REQ_SET, 3'd3, 1'b1, 16'd0);
        send_req(REQ_SET, 3'd2, 1'b1, 16'd0);
        send_req(REQ_SET, 3'd5, 1'b1, 16'd0);
        send_req(REQ_GET, 3'd0, 1'b0, 16'd0);
        send_req(REQ_GET, 3'd3, 1'b0, 16'd0);
        send_req(REQ_GET, 3'd4, 1'b0, 16'd0);
        drain();
    endtask

    task automatic test_pulse_timing();
        write_masks(4'b1111, 4'b1010);
        send_req(REQ_PULSE, 3'd0, 1'b0, 16'd0);
        send_req(REQ_PULSE, 3'd1, 1'b1, 16'hFFFF);
        send_req(REQ_PULSE, 3'd2, 1'b0, 16'd2);
        send_req(REQ_PULSE, 3'd6, 1'b0, 16'd1);
        send_req(REQ_TICK, 3'd0, 1'b0, 16'd0);
        send_req(REQ_TICK, 3'd0, 1'b0, 16'd0);
        send_req(REQ_PULSE, 3'd3, 1'b0, 16'd5);
        send_req(REQ_SET, 3'd3, 1'b0, 16'd0);
        send_req(REQ_TICK, 3'd0, 1'b0, 16'd0);
        send_req(REQ_INIT, 3'd0, 1'b0, 16'd0);
        send_req(REQ_GET, 3'd1, 1'b0, 16'd0);
        drain();
    endtask

    task automatic test_backpressure();
        no_idle = 1;
        hold_req = 1;
        repeat (60) send_random_req();
        drain();
        no_idle = 0;
    endtask

    task automatic test_random_traffic();
        logic [MASK_W-1:0] en;
        logic [MASK_W-1:0] safe;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin en = 4'hF; safe = 4'h0; end
                1: begin en = 4'hF; safe = 4'hF; end
                2: begin en = 4'h0; safe = 4'h0; end
                default: begin en = MASK_W'($urandom); safe = MASK_W'($urandom); end
            endcase
            write_masks(en, safe);
            no_idle = (phase == 4);
            repeat (120) send_random_req();
            drain();
        end
        no_idle = 0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_relay_index = '0;
        i_relay_on = 1'b0;
        i_pulse_ms = '0;
        clear_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rejects();
        test_levels();
        test_pulse_timing();
        test_backpressure();
        test_random_traffic();

        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("relay_pulse_controller verification clean");
        end else begin
            $display("relay_pulse_controller verification failed");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("relay_pulse_controller verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rpc_pkg.sv
sv/relay_pulse_controller.sv
sv/rpc_checker.sv
tb/sv/tb_relay_pulse_controller.sv
